>>> rtl/core/iaop_pkg.sv
// shared types and codes for the integer alu with overflow promotion
`timescale 1ns / 1ps

package iaop_pkg;

    localparam int unsigned OPW = 32;
    localparam int unsigned RESW = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_ABS = 3'd5,
        OP_NEG = 3'd6,
        OP_ID  = 3'd7
    } op_t;

    // classified item passed from front to back
    typedef struct packed {
        op_t                    op;
        logic signed [OPW-1:0]  a;
        logic signed [OPW-1:0]  b;
        logic                   is_div;
        logic                   div_zero;
        logic [OPW-1:0]         a_mag;
        logic [OPW-1:0]         b_mag;
        logic                   q_neg;
        logic                   r_neg;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/iaop_front.sv
// front stage: accepts items and classifies them
`timescale 1ns / 1ps

module iaop_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic signed [31:0]          operand_a,
    input  logic signed [31:0]          operand_b,
    input  iaop_pkg::q_status_t         q_status,
    output logic                        push,
    output iaop_pkg::item_t             push_item
);
    import iaop_pkg::*;

    logic  fv_reg;
    item_t item_reg;
    item_t item_next;
    logic  adv;

    assign adv = !fv_reg || !q_status.full;
    assign in_stall = fv_reg && q_status.full;
    assign push = fv_reg && !q_status.full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.op       = op_t'(op);
        item_next.a        = operand_a;
        item_next.b        = operand_b;
        item_next.is_div   = (op_t'(op) == OP_DIV) || (op_t'(op) == OP_MOD);
        item_next.div_zero = (operand_b == '0);
        item_next.a_mag    = operand_a[OPW-1] ? (~operand_a + 1'b1) : operand_a;
        item_next.b_mag    = operand_b[OPW-1] ? (~operand_b + 1'b1) : operand_b;
        item_next.q_neg    = operand_a[OPW-1] ^ operand_b[OPW-1];
        item_next.r_neg    = operand_a[OPW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/core/iaop_queue.sv
// short item queue between front and back
`timescale 1ns / 1ps

module iaop_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  iaop_pkg::item_t             push_item,
    input  logic                        pop,
    output iaop_pkg::item_t             head_item,
    output iaop_pkg::q_status_t         q_status
);
    import iaop_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW = $clog2(DEPTH);

    item_t           mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign q_status.full  = (count_reg == (PW+1)'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> rtl/core/iaop_back.sv
// back pipeline: arithmetic, bit-per-stage divider and result register
`timescale 1ns / 1ps

module iaop_back #(
    parameter int unsigned INT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iaop_pkg::item_t             head_item,
    input  iaop_pkg::q_status_t         q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [63:0]          value,
    output logic                        promoted,
    output logic                        error_code
);
    import iaop_pkg::*;

    // stage 0 computes non-divide results, stages 1..OPW divide, then a separate output register
    localparam int unsigned NS = OPW + 1;

    logic                   v_reg    [NS];
    logic signed [RESW-1:0] res_reg  [NS];
    logic                   div_reg  [NS];
    logic                   mod_reg  [NS];
    logic                   dz_reg   [NS];
    logic                   qn_reg   [NS];
    logic                   rn_reg   [NS];
    logic [OPW-1:0]         rem_reg  [NS];
    logic [OPW-1:0]         quo_reg  [NS];
    logic [OPW-1:0]         dvs_reg  [NS];

    logic                   ov_reg;
    logic signed [RESW-1:0] value_reg;
    logic                   prom_reg;
    logic                   err_reg;

    logic                   adv;
    logic signed [RESW-1:0] res0;
    logic signed [RESW-1:0] a64;
    logic signed [RESW-1:0] b64;
    logic signed [RESW-1:0] fin_val;
    logic [RESW-1:0]        q64;
    logic [RESW-1:0]        r64;

    assign adv = !ov_reg || !out_stall;
    assign pop = adv && !q_status.empty;

    assign a64 = RESW'(head_item.a);
    assign b64 = RESW'(head_item.b);

    always_comb
    begin
        unique case (head_item.op)
            OP_ADD:  res0 = a64 + b64;
            OP_SUB:  res0 = a64 - b64;
            OP_MUL:  res0 = head_item.a * head_item.b;
            OP_DIV:  res0 = '0;
            OP_MOD:  res0 = '0;
            OP_ABS:  res0 = head_item.a[OPW-1] ? -a64 : a64;
            OP_NEG:  res0 = -a64;
            OP_ID:   res0 = a64;
            default: res0 = a64;
        endcase
    end

    // sign fix of the divider output and final select
    always_comb
    begin
        q64 = {{(RESW-OPW){1'b0}}, quo_reg[NS-1]};
        r64 = {{(RESW-OPW){1'b0}}, rem_reg[NS-1]};
        if (!div_reg[NS-1])
        begin
            fin_val = res_reg[NS-1];
        end
        else if (dz_reg[NS-1])
        begin
            fin_val = '0;
        end
        else if (mod_reg[NS-1])
        begin
            fin_val = rn_reg[NS-1] ? -$signed(r64) : $signed(r64);
        end
        else
        begin
            fin_val = qn_reg[NS-1] ? -$signed(q64) : $signed(q64);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pop;
            for (int k = 1; k < NS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            ov_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [OPW:0] t;
        if (adv)
        begin
            res_reg[0] <= res0;
            div_reg[0] <= head_item.is_div;
            mod_reg[0] <= (head_item.op == OP_MOD);
            dz_reg[0]  <= head_item.div_zero;
            qn_reg[0]  <= head_item.q_neg;
            rn_reg[0]  <= head_item.r_neg;
            rem_reg[0] <= '0;
            quo_reg[0] <= head_item.a_mag;
            dvs_reg[0] <= head_item.b_mag;
            for (int k = 1; k < NS; k++)
            begin
                t = {rem_reg[k-1], quo_reg[k-1][OPW-1]};
                res_reg[k] <= res_reg[k-1];
                div_reg[k] <= div_reg[k-1];
                mod_reg[k] <= mod_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
                qn_reg[k]  <= qn_reg[k-1];
                rn_reg[k]  <= rn_reg[k-1];
                dvs_reg[k] <= dvs_reg[k-1];
                if (t >= {1'b0, dvs_reg[k-1]})
                begin
                    rem_reg[k] <= OPW'(t - {1'b0, dvs_reg[k-1]});
                    quo_reg[k] <= {quo_reg[k-1][OPW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= t[OPW-1:0];
                    quo_reg[k] <= {quo_reg[k-1][OPW-2:0], 1'b0};
                end
            end
            value_reg <= fin_val;
            err_reg   <= div_reg[NS-1] && dz_reg[NS-1];
            prom_reg  <= !(div_reg[NS-1] && dz_reg[NS-1])
                         && (fin_val != RESW'($signed(fin_val[INT_WIDTH-1:0])));
        end
    end

    assign out_valid  = ov_reg;
    assign value      = value_reg;
    assign promoted   = prom_reg;
    assign error_code = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code) |-> (value == '0 && !promoted))
        else $error("error item with nonzero value or promotion");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value)))
        else $error("stalled result changed");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> adv)
        else $error("queue popped while pipeline held");

endmodule

>>> rtl/core/int_alu_overflow_promote_top.sv
// top level of the signed integer alu with overflow promotion flag
`timescale 1ns / 1ps
// path from item accept to result valid: front register, queue write, arithmetic stage,
//   32 divider stages, output register; a full queue or out_stall can hold items on the way
// throughput: one item per cycle when not stalled; one quotient bit per divider stage
// reset: rst_n async active low clears all valid bits and queue pointers
// a 4-entry queue decouples the classify front from the execute back

module int_alu_overflow_promote_top #(
    parameter int unsigned INT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          op,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  value,
    output logic                promoted,
    output logic                error_code
);
    import iaop_pkg::*;

    // front to queue
    logic      push;
    item_t     push_item;
    // queue to back
    item_t     head_item;
    q_status_t q_status;
    logic      pop;

    iaop_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    iaop_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // promotion range follows INT_WIDTH; operands stay full width
    iaop_back #(
        .INT_WIDTH (INT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .promoted   (promoted),
        .error_code (error_code)
    );

endmodule
